// ===== hdl/sha1md_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types, constants and round functions for the SHA-1 digest unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

  localparam int NUM_H     = 5;
  localparam int BUF_WORDS = 16;
  localparam int ROUNDS    = 80;
  localparam int FILL_W    = $clog2(BUF_WORDS);
  localparam int RCNT_W    = $clog2(ROUNDS);
  localparam int IDX_W     = 3;

  localparam logic [31:0] SEED [NUM_H] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_CH    = 32'h5A827999;
  localparam logic [31:0] K_PAR_LO = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ   = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR_HI = 32'hCA62C1D6;

  localparam logic [31:0] PAD_MARK_WORD = 32'h80000000;

  // Source of the word pushed into the block buffer
  typedef enum logic [2:0] {
    SEL_MSG,
    SEL_TAIL,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN_HI,
    SEL_LEN_LO
  } word_sel_t;

  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR_LO,
    PH_MAJ,
    PH_PAR_HI
  } round_phase_t;

  typedef struct packed {
    logic         push;
    word_sel_t    sel;
    logic         len_add;
    logic [2:0]   len_bytes;
    logic         round_load;
    logic         round_step;
    round_phase_t phase;
    logic         fold;
    logic         out_load;
  } sha1md_cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              out_busy;
  } sha1md_stat_t;

  function automatic logic [31:0] round_f(round_phase_t ph, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
    logic [31:0] r;
    case (ph)
      PH_CH:   r = (b & c) | (~b & d);
      PH_MAJ:  r = (b & c) | (b & d) | (c & d);
      default: r = b ^ c ^ d;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(round_phase_t ph);
    logic [31:0] r;
    case (ph)
      PH_CH:     r = K_CH;
      PH_PAR_LO: r = K_PAR_LO;
      PH_MAJ:    r = K_MAJ;
      default:   r = K_PAR_HI;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sha1md_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1md_ctrl
// Sequencer: word intake, padding, round count, digest hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_ctrl
  import sha1md_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [2:0]   byte_count,
  input  wire logic         last,
  input  sha1md_stat_t      stat,
  output sha1md_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_FOLD  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BUF_WORDS - 1);
  localparam logic [FILL_W-1:0] FILL_LEN  = FILL_W'(BUF_WORDS - 2);
  localparam logic [RCNT_W-1:0] RCNT_LAST = RCNT_W'(ROUNDS - 1);

  state_t            state, state_next;
  logic              pad_mode, pad_mode_next;
  logic              extra80, extra80_next;
  logic              len_phase, len_phase_next;
  logic [RCNT_W-1:0] rcnt, rcnt_next;
  logic [2:0]        cnt_c;
  word_sel_t         pad_sel;

  assign cnt_c = (byte_count > 3'd4) ? 3'd4 : byte_count;

  always_comb begin
    if (extra80) begin
      pad_sel = SEL_PAD80;
    end else if (len_phase) begin
      pad_sel = SEL_LEN_LO;
    end else if (stat.fill == FILL_LEN) begin
      pad_sel = SEL_LEN_HI;
    end else begin
      pad_sel = SEL_ZERO;
    end
  end

  always_comb begin
    state_next     = state;
    pad_mode_next  = pad_mode;
    extra80_next   = extra80;
    len_phase_next = len_phase;
    rcnt_next      = rcnt;
    cmd            = '0;
    in_ready       = 1'b0;

    if (rcnt < RCNT_W'(20)) begin
      cmd.phase = PH_CH;
    end else if (rcnt < RCNT_W'(40)) begin
      cmd.phase = PH_PAR_LO;
    end else if (rcnt < RCNT_W'(60)) begin
      cmd.phase = PH_MAJ;
    end else begin
      cmd.phase = PH_PAR_HI;
    end

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!last) begin
            if (cnt_c != 3'd0) begin
              cmd.push      = 1'b1;
              cmd.sel       = SEL_MSG;
              cmd.len_add   = 1'b1;
              cmd.len_bytes = 3'd4;
              if (stat.fill == FILL_LAST) begin
                cmd.round_load = 1'b1;
                state_next     = S_ROUND;
              end
            end
          end else begin
            cmd.push       = 1'b1;
            cmd.sel        = (cnt_c == 3'd4) ? SEL_MSG : SEL_TAIL;
            cmd.len_add    = 1'b1;
            cmd.len_bytes  = cnt_c;
            pad_mode_next  = 1'b1;
            extra80_next   = (cnt_c == 3'd4);
            len_phase_next = 1'b0;
            if (stat.fill == FILL_LAST) begin
              cmd.round_load = 1'b1;
              state_next     = S_ROUND;
            end else begin
              state_next = S_PAD;
            end
          end
        end
      end
      S_PAD: begin
        cmd.push = 1'b1;
        cmd.sel  = pad_sel;
        if (pad_sel == SEL_PAD80) begin
          extra80_next = 1'b0;
        end
        if (pad_sel == SEL_LEN_HI) begin
          len_phase_next = 1'b1;
        end
        if (stat.fill == FILL_LAST) begin
          cmd.round_load = 1'b1;
          state_next     = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        if (rcnt == RCNT_LAST) begin
          rcnt_next  = '0;
          state_next = S_FOLD;
        end else begin
          rcnt_next = rcnt + RCNT_W'(1);
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (len_phase) begin
          state_next = S_OUT;
        end else if (pad_mode) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        // wait for the previous digest to drain out of the output stage
        if (!stat.out_busy) begin
          cmd.out_load   = 1'b1;
          pad_mode_next  = 1'b0;
          extra80_next   = 1'b0;
          len_phase_next = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pad_mode  <= 1'b0;
      extra80   <= 1'b0;
      len_phase <= 1'b0;
      rcnt      <= '0;
    end else begin
      state     <= state_next;
      pad_mode  <= pad_mode_next;
      extra80   <= extra80_next;
      len_phase <= len_phase_next;
      rcnt      <= rcnt_next;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state not one-hot");

  a_rcnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_ROUND) |-> (rcnt == '0))
    else $error("round counter nonzero outside round state");

  a_fold_after_80: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOLD) |-> ($past(state) == S_ROUND && $past(rcnt) == RCNT_LAST))
    else $error("fold entered without completing 80 rounds");

  a_push_when_filling: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (state == S_IDLE || state == S_PAD))
    else $error("buffer push during compression");

  a_len_before_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (len_phase && pad_mode))
    else $error("digest hand-off without length words pushed");

endmodule

`default_nettype wire

// ===== hdl/sha1md_dp.sv =====
// ----------------------------------------------------------------------------
// sha1md_dp
// Datapath: block buffer / schedule shift line, round registers, chaining
// words, bit length and the digest output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_dp
  import sha1md_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  sha1md_cmd_t           cmd,
  output sha1md_stat_t          stat,
  input  wire logic [31:0]      data_word,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           digest_word,
  output logic [IDX_W-1:0]      word_index,
  output logic                  final_word
);

  logic [31:0]       sched [BUF_WORDS];
  logic [31:0]       chain [NUM_H];
  logic [31:0]       out_words [NUM_H];
  logic [31:0]       va, vb, vc, vd, ve;
  logic [FILL_W-1:0] fill;
  logic [63:0]       bit_length;
  logic [IDX_W-1:0]  out_left;
  logic [IDX_W-1:0]  out_idx;
  logic [31:0]       push_word;
  logic [31:0]       tail_word;
  logic [31:0]       sched_mix;
  logic [31:0]       sched_new;
  logic [31:0]       t_sum;
  logic              out_take;

  always_comb begin
    case (cmd.len_bytes[1:0])
      2'd0:    tail_word = PAD_MARK_WORD;
      2'd1:    tail_word = {data_word[31:24], 24'h800000};
      2'd2:    tail_word = {data_word[31:16], 16'h8000};
      default: tail_word = {data_word[31:8], 8'h80};
    endcase
  end

  always_comb begin
    case (cmd.sel)
      SEL_MSG:    push_word = data_word;
      SEL_TAIL:   push_word = tail_word;
      SEL_PAD80:  push_word = PAD_MARK_WORD;
      SEL_LEN_HI: push_word = bit_length[63:32];
      SEL_LEN_LO: push_word = bit_length[31:0];
      default:    push_word = '0;
    endcase
  end

  // sched[k] holds W[t+k]; the new word is W[t+16]
  assign sched_mix = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
  assign sched_new = {sched_mix[30:0], sched_mix[31]};

  assign t_sum = {va[26:0], va[31:27]} + round_f(cmd.phase, vb, vc, vd) + ve
               + round_k(cmd.phase) + sched[0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < BUF_WORDS - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[BUF_WORDS-1] <= push_word;
    end else if (cmd.round_step) begin
      for (int i = 0; i < BUF_WORDS - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[BUF_WORDS-1] <= sched_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_load) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
      ve <= chain[4];
    end else if (cmd.round_step) begin
      va <= t_sum;
      vb <= va;
      vc <= {vb[1:0], vb[31:2]};
      vd <= vc;
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_H; i++) begin
        chain[i] <= SEED[i];
      end
      fill       <= '0;
      bit_length <= '0;
    end else begin
      if (cmd.fold) begin
        chain[0] <= chain[0] + va;
        chain[1] <= chain[1] + vb;
        chain[2] <= chain[2] + vc;
        chain[3] <= chain[3] + vd;
        chain[4] <= chain[4] + ve;
      end else if (cmd.out_load) begin
        for (int i = 0; i < NUM_H; i++) begin
          chain[i] <= SEED[i];
        end
      end
      if (cmd.push) begin
        fill <= fill + FILL_W'(1);
      end
      if (cmd.out_load) begin
        bit_length <= '0;
      end else if (cmd.len_add) begin
        bit_length <= bit_length + {58'd0, cmd.len_bytes, 3'd0};
      end
    end
  end

  // digest output stage
  assign out_valid = (out_left != '0);
  assign out_take  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_left <= '0;
      out_idx  <= '0;
    end else if (cmd.out_load) begin
      out_left <= IDX_W'(NUM_H);
      out_idx  <= '0;
    end else if (out_take) begin
      out_left <= out_left - IDX_W'(1);
      out_idx  <= out_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < NUM_H; i++) begin
        out_words[i] <= chain[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < NUM_H - 1; i++) begin
        out_words[i] <= out_words[i+1];
      end
    end
  end

  assign digest_word = out_words[0];
  assign word_index  = out_idx;
  assign final_word  = (out_idx == IDX_W'(NUM_H - 1));

  assign stat.fill     = fill;
  assign stat.out_busy = out_valid;

  a_out_left_range: assert property (@(posedge clk) disable iff (rst)
    out_left <= IDX_W'(NUM_H))
    else $error("output count out of range");

  a_out_index_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_idx) + 32'(out_left) == NUM_H))
    else $error("output index and count disagree");

  a_load_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid)
    else $error("digest load over undelivered words");

endmodule

`default_nettype wire

// ===== hdl/sha1_message_digest_unit.sv =====
// ----------------------------------------------------------------------------
// sha1_message_digest_unit
// SHA-1 digest of a byte message streamed as big-endian 32-bit words.
// ----------------------------------------------------------------------------
// A message word is taken only while the unit is idle. Every 16th
// word starts a compression of 80 rounds, one round per cycle on a single
// round unit, followed by a fold of the result into the chaining words.
// The word with last set is followed by 2 to 18 padding/length pushes and
// one or two compressions; the five digest words are then loaded into an
// output stage and leave one per accepted request, index 0 first, while the
// next message is already being taken in. Padding and the chaining reset to
// the seed are automatic.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest_unit
  import sha1md_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [31:0]      data_word,
  input  wire logic [2:0]       byte_count,
  input  wire logic             last,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           digest_word,
  output logic [IDX_W-1:0]      word_index,
  output logic                  final_word
);

  sha1md_cmd_t  cmd;
  sha1md_stat_t stat;

  sha1md_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_count (byte_count),
    .last       (last),
    .stat       (stat),
    .cmd        (cmd)
  );

  sha1md_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .data_word   (data_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .final_word  (final_word)
  );

endmodule

`default_nettype wire
